// ===== src/kdh_pkg.sv =====
`default_nettype none
package kdh_pkg;

	// Field widths of the sample and result streams.
	localparam int unsigned TimeW   = 32;
	localparam int unsigned CharW   = 8;
	localparam int unsigned IntW    = 16;
	localparam int unsigned PhaseW  = 3;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 48;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_MAIN_CHAR    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ALT_CHAR     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY_TYPE     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_HOLD         = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_REPEAT_DELAY = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_REPEAT_ACCEL = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_REPEAT_MIN   = 3'd7;

	// Key types.
	localparam logic [1:0] KT_REPEAT_NOW  = 2'd0;
	localparam logic [1:0] KT_HOLD_ONLY   = 2'd1;
	localparam logic [1:0] KT_REPEAT_HOLD = 2'd2;

	// Register reset values.
	localparam logic [IntW-1:0] DEBOUNCE_RST     = 16'd20;
	localparam logic [IntW-1:0] HOLD_RST         = 16'd500;
	localparam logic [IntW-1:0] REPEAT_DELAY_RST = 16'd400;
	localparam logic [IntW-1:0] REPEAT_ACCEL_RST = 16'd0;
	localparam logic [IntW-1:0] REPEAT_MIN_RST   = 16'd50;

	// Phase codes as reported on the result stream.
	localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
	localparam logic [PhaseW-1:0] PH_PRESSED   = 3'd1;
	localparam logic [PhaseW-1:0] PH_HOLD      = 3'd2;
	localparam logic [PhaseW-1:0] PH_RELEASED  = 3'd3;
	localparam logic [PhaseW-1:0] PH_REPEATING = 3'd4;

	// Key machine state, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_PRESSED   = 5'b00010,
		ST_HOLD      = 5'b00100,
		ST_RELEASED  = 5'b01000,
		ST_REPEATING = 5'b10000
	} key_state_t;

	// Maps a state to its reported phase code.
	function automatic logic [PhaseW-1:0] phase_code(input key_state_t st);
		logic [PhaseW-1:0] code;
		case (st)
			ST_IDLE:      code = PH_IDLE;
			ST_PRESSED:   code = PH_PRESSED;
			ST_HOLD:      code = PH_HOLD;
			ST_RELEASED:  code = PH_RELEASED;
			ST_REPEATING: code = PH_REPEATING;
			default:      code = PH_IDLE;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

// ===== src/key_debounce_hold_autorepeat.sv =====
`default_nettype none
// Key debouncer with hold detection and typematic repeat.
//
// Samples arrive on the s_ stream (raw contact level and a millisecond
// timestamp); each sample yields exactly one result on the m_ stream with
// the emitted character (0 for none), the key phase, the debounced level,
// a change flag and the press duration.
// Settings are written through the cfg_ channel (index, 16-bit data); the
// user must write only while no sample is in flight, as the block does not
// enforce it. cfg_ready is always high. Each sample request passes the input
// register, then the key logic feeding the result register. Throughput is
// one sample per cycle while the receiver keeps up, set by the single key
// state update per sample. When the receiver stalls, the result register
// holds and the input register can still take one more sample; s_tready
// drops only when both are full.
// Reset clears both stages, returns the key machine to idle with all
// timers at zero and loads the documented register defaults.
module key_debounce_hold_autorepeat (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// s_tdata: key_closed [0], now_ms [32:1], zero fill [39:33]
	input  wire  [kdh_pkg::InDataW-1:0]      s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// m_tdata: emitted_char [7:0], key_phase [10:8], debounced_level [11],
	// changed_flag [12], press_duration_ms [44:13], zero fill [47:45]
	output logic [kdh_pkg::OutDataW-1:0]     m_tdata,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [kdh_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire  [kdh_pkg::CfgDataW-1:0]     cfg_data
);
	import kdh_pkg::*;

	// Configuration registers.
	logic [CharW-1:0] main_char_q, alt_char_q;
	logic [1:0]       key_type_q;
	logic [IntW-1:0]  debounce_q, hold_q, repeat_delay_q, repeat_accel_q, repeat_min_q;

	// Key state.
	logic             stable_q, prev_raw_q;
	key_state_t       state_q;
	logic [TimeW-1:0] last_edge_q, repeat_base_q;
	logic [IntW-1:0]  interval_q;

	// Pipeline registers.
	logic             valid_s1;
	logic             raw_s1;
	logic [TimeW-1:0] now_s1;
	logic             valid_s2;
	logic [CharW-1:0] emit_s2;
	logic [PhaseW-1:0] phase_s2;
	logic             level_s2, changed_s2;
	logic [TimeW-1:0] duration_s2;

	logic advance;

	// Next-state values of the key logic.
	logic             edge_seen;
	logic [TimeW-1:0] last_edge_n, elapsed, since_base;
	logic             stable_n, level_chg;
	key_state_t       state_n;
	logic [TimeW-1:0] repeat_base_n;
	logic [IntW-1:0]  interval_n, shrunk;
	logic [IntW:0]    diff_ext;
	logic [CharW-1:0] emit_n;
	logic             repeat_due;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {3'b000, duration_s2, changed_s2, level_s2, phase_s2, emit_s2};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_char_q    <= '0;
			alt_char_q     <= '0;
			key_type_q     <= KT_REPEAT_NOW;
			debounce_q     <= DEBOUNCE_RST;
			hold_q         <= HOLD_RST;
			repeat_delay_q <= REPEAT_DELAY_RST;
			repeat_accel_q <= REPEAT_ACCEL_RST;
			repeat_min_q   <= REPEAT_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAIN_CHAR:    main_char_q    <= cfg_data[CharW-1:0];
				REG_ALT_CHAR:     alt_char_q     <= cfg_data[CharW-1:0];
				REG_KEY_TYPE:     key_type_q     <= cfg_data[1:0];
				REG_DEBOUNCE:     debounce_q     <= cfg_data;
				REG_HOLD:         hold_q         <= cfg_data;
				REG_REPEAT_DELAY: repeat_delay_q <= cfg_data;
				REG_REPEAT_ACCEL: repeat_accel_q <= cfg_data;
				REG_REPEAT_MIN:   repeat_min_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[0];
			now_s1 <= s_tdata[TimeW:1];
		end
	end

	// Debounce: a raw change restarts the edge timer.
	always_comb begin
		edge_seen   = raw_s1 != prev_raw_q;
		last_edge_n = edge_seen ? now_s1 : last_edge_q;
		elapsed     = now_s1 - last_edge_n;
		level_chg   = (elapsed > {16'd0, debounce_q}) && (raw_s1 != stable_q);
		stable_n    = level_chg ? raw_s1 : stable_q;
	end

	// Repeat timing and interval shrink with floor.
	always_comb begin
		since_base = now_s1 - repeat_base_q;
		repeat_due = since_base >= {16'd0, interval_q};
		diff_ext   = {1'b0, interval_q} - {1'b0, repeat_accel_q};
		if (!diff_ext[IntW] && (diff_ext[IntW-1:0] > repeat_min_q)) begin
			shrunk = diff_ext[IntW-1:0];
		end else begin
			shrunk = repeat_min_q;
		end
	end

	// Key machine.
	always_comb begin
		state_n       = state_q;
		emit_n        = '0;
		repeat_base_n = repeat_base_q;
		interval_n    = interval_q;
		case (state_q)
			ST_IDLE: begin
				if (stable_n) begin
					repeat_base_n = now_s1;
					state_n = (key_type_q == KT_REPEAT_NOW) ? ST_REPEATING : ST_PRESSED;
				end
			end
			ST_PRESSED: begin
				if (level_chg) begin
					state_n = ST_RELEASED;
					emit_n  = main_char_q;
				end else if (elapsed > {16'd0, hold_q}) begin
					if (key_type_q == KT_REPEAT_HOLD) begin
						state_n = ST_REPEATING;
					end else begin
						state_n = ST_HOLD;
						emit_n  = alt_char_q;
					end
				end
			end
			ST_HOLD: begin
				if (level_chg) begin
					state_n = ST_RELEASED;
				end
			end
			ST_RELEASED: begin
				state_n    = ST_IDLE;
				interval_n = repeat_delay_q;
			end
			ST_REPEATING: begin
				if (level_chg) begin
					state_n = ST_RELEASED;
					emit_n  = alt_char_q;
				end else if (repeat_due) begin
					repeat_base_n = repeat_base_q + {16'd0, interval_q};
					interval_n    = shrunk;
					emit_n        = alt_char_q;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Key state update, once per sample moved to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q      <= 1'b0;
			prev_raw_q    <= 1'b0;
			state_q       <= ST_IDLE;
			last_edge_q   <= '0;
			repeat_base_q <= '0;
			interval_q    <= REPEAT_DELAY_RST;
		end else if (advance) begin
			stable_q      <= stable_n;
			prev_raw_q    <= raw_s1;
			state_q       <= state_n;
			last_edge_q   <= last_edge_n;
			repeat_base_q <= repeat_base_n;
			interval_q    <= interval_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			emit_s2     <= emit_n;
			phase_s2    <= phase_code(state_n);
			level_s2    <= stable_n;
			changed_s2  <= level_chg || (state_n != state_q);
			duration_s2 <= stable_n ? elapsed : '0;
		end
	end

endmodule
`default_nettype wire

// ===== src/kdh_checker.sv =====
`default_nettype none
// Port-level checks for the key debouncer.
module kdh_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [kdh_pkg::OutDataW-1:0]  m_tdata
);
	import kdh_pkg::*;

	// A stalled result keeps its contents.
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// The press duration is only reported while the key is down.
	a_duration_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[11] |-> m_tdata[44:13] == '0)
		else $error("press duration reported with key up");

	// A character comes only with a phase change or from a repeat.
	a_emit_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[7:0] != '0) |->
			m_tdata[12] || (m_tdata[10:8] == PH_REPEATING))
		else $error("character emitted without cause");

	// The released phase is always entered from another phase.
	a_release_changed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[10:8] == PH_RELEASED) |-> m_tdata[12])
		else $error("released phase without change flag");

endmodule

bind key_debounce_hold_autorepeat kdh_checker u_kdh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ===== tb/key_debounce_hold_autorepeat_tb.sv =====
module key_debounce_hold_autorepeat_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kdh_pkg::*;

	// One expected result of the key logic.
	typedef struct {
		logic [CharW-1:0]  emit_char;
		logic [PhaseW-1:0] phase;
		logic              level;
		logic              changed;
		logic [TimeW-1:0]  press_ms;
	} key_report_t;

	// Receiver stall styles.
	typedef enum {RX_FLOW, RX_COIN, RX_SPARSE} rx_style_t;

	// Predicts the key machine and checks each result against the oldest prediction.
	class key_report_board;
		logic [CharW-1:0]  main_ch, alt_ch;
		logic [1:0]        key_kind;
		logic [IntW-1:0]   debounce_lim, hold_lim, delay_init, accel_step, interval_floor;
		logic              level_q, raw_q;
		logic [PhaseW-1:0] phase_q;
		logic [TimeW-1:0]  edge_ms, repeat_base_ms;
		logic [IntW-1:0]   interval_ms;
		key_report_t       pending[$];
		int unsigned       fails;

		function new();
			main_ch = '0;
			alt_ch = '0;
			key_kind = KT_REPEAT_NOW;
			debounce_lim = DEBOUNCE_RST;
			hold_lim = HOLD_RST;
			delay_init = REPEAT_DELAY_RST;
			accel_step = REPEAT_ACCEL_RST;
			interval_floor = REPEAT_MIN_RST;
			level_q = 1'b0;
			raw_q = 1'b0;
			phase_q = PH_IDLE;
			edge_ms = '0;
			repeat_base_ms = '0;
			interval_ms = REPEAT_DELAY_RST;
			fails = 0;
		endfunction

		function void write_setting(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
			case (idx)
				REG_MAIN_CHAR:    main_ch = val[CharW-1:0];
				REG_ALT_CHAR:     alt_ch = val[CharW-1:0];
				REG_KEY_TYPE:     key_kind = val[1:0];
				REG_DEBOUNCE:     debounce_lim = val;
				REG_HOLD:         hold_lim = val;
				REG_REPEAT_DELAY: delay_init = val;
				REG_REPEAT_ACCEL: accel_step = val;
				REG_REPEAT_MIN:   interval_floor = val;
				default: ;
			endcase
		endfunction

		function void note_sample(logic raw, logic [TimeW-1:0] now);
			key_report_t       rep;
			logic [PhaseW-1:0] next_phase;
			logic [TimeW-1:0]  since_edge, since_repeat;
			logic              level_moved;
			rep.emit_char = '0;
			level_moved = 1'b0;
			next_phase = phase_q;

			// Any raw change restarts the edge timer; the level follows once stable.
			if (raw != raw_q)
				edge_ms = now;
			raw_q = raw;
			since_edge = now - edge_ms;
			if (since_edge > debounce_lim && raw != level_q) begin
				level_q = raw;
				level_moved = 1'b1;
			end

			case (phase_q)
				PH_IDLE: begin
					if (level_q) begin
						repeat_base_ms = now;
						next_phase = (key_kind == KT_REPEAT_NOW) ? PH_REPEATING : PH_PRESSED;
					end
				end
				PH_PRESSED: begin
					if (level_moved) begin
						next_phase = PH_RELEASED;
						rep.emit_char = main_ch;
					end else if (since_edge > hold_lim) begin
						if (key_kind == KT_REPEAT_HOLD) begin
							next_phase = PH_REPEATING;
						end else begin
							next_phase = PH_HOLD;
							rep.emit_char = alt_ch;
						end
					end
				end
				PH_HOLD: begin
					if (level_moved)
						next_phase = PH_RELEASED;
				end
				PH_RELEASED: begin
					next_phase = PH_IDLE;
					interval_ms = delay_init;
				end
				PH_REPEATING: begin
					since_repeat = now - repeat_base_ms;
					if (level_moved) begin
						next_phase = PH_RELEASED;
						rep.emit_char = alt_ch;
					end else if (since_repeat >= interval_ms) begin
						// Each repeat moves the base and shrinks the interval by the step, to no less than the floor.
						repeat_base_ms = repeat_base_ms + interval_ms;
						if (interval_ms >= accel_step && interval_ms - accel_step > interval_floor)
							interval_ms = interval_ms - accel_step;
						else
							interval_ms = interval_floor;
						rep.emit_char = alt_ch;
					end
				end
				default: ;
			endcase

			rep.changed = level_moved || (next_phase != phase_q);
			phase_q = next_phase;
			rep.phase = phase_q;
			rep.level = level_q;
			rep.press_ms = level_q ? since_edge : '0;
			pending.push_back(rep);
		endfunction

		function void compare_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_report(logic [OutDataW-1:0] data);
			key_report_t want;
			if (pending.size() == 0) begin
				$display("%0t: result %h arrived with no sample pending", $time, data);
				fails++;
				return;
			end
			want = pending.pop_front();
			compare_field("emitted_char", want.emit_char, data[CharW-1:0]);
			compare_field("key_phase", want.phase, data[CharW +: PhaseW]);
			compare_field("debounced_level", want.level, data[CharW+PhaseW]);
			compare_field("changed_flag", want.changed, data[CharW+PhaseW+1]);
			compare_field("press_duration_ms", want.press_ms, data[CharW+PhaseW+2 +: TimeW]);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	key_report_board     board;
	logic [CfgDataW-1:0] setting_vals [1 << CfgIdxW];
	logic [TimeW-1:0]    clock_ms;
	int unsigned         burst_left;
	int unsigned         samples_sent;
	rx_style_t           rx_mode = RX_FLOW;
	int unsigned         rx_left = 0;
	int unsigned         rx_div = 2;

	key_debounce_hold_autorepeat u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sends one sample request; the sender runs in bursts with short gaps between.
	task automatic send_sample(input logic raw, input logic [TimeW-1:0] now);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(InDataW-TimeW-1){1'b0}}, now, raw};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_sample(raw, now);
		burst_left--;
		samples_sent++;
		clock_ms = now;
		@(negedge clk);
	endtask

	// Stops the sample stream and waits for every expected result.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		burst_left = 0;
		while (board.pending.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_setting(idx, val);
		@(negedge clk);
	endtask

	// Writes every register from setting_vals, starting at a random index.
	task automatic load_settings();
		logic [CfgIdxW-1:0] idx;
		wait_drained();
		idx = CfgIdxW'($urandom());
		repeat (1 << CfgIdxW) begin
			write_reg(idx, setting_vals[idx]);
			idx++;
		end
		cfg_valid = 1'b0;
	endtask

	function automatic logic [CfgDataW-1:0] pick_ms(input int unsigned typical);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return CfgDataW'($urandom_range(0, typical));
		endcase
	endfunction

	// Random settings for one phase of the run; the first two are the extremes.
	task automatic pick_settings(input int unsigned p);
		logic [1:0] kind;
		kind = 2'(p % 4);
		foreach (setting_vals[i])
			setting_vals[i] = (p == 1) ? '1 : CfgDataW'($urandom());
		if (p == 1)
			return;
		if ($urandom_range(0, 7) == 0)
			setting_vals[REG_MAIN_CHAR][CharW-1:0] = '0;
		if ($urandom_range(0, 7) == 0)
			setting_vals[REG_ALT_CHAR][CharW-1:0] = '0;
		setting_vals[REG_KEY_TYPE][1:0] = (p == 0) ? KT_REPEAT_NOW : kind;
		if (p == 0) begin
			setting_vals[REG_DEBOUNCE] = '0;
			setting_vals[REG_HOLD] = '0;
			setting_vals[REG_REPEAT_DELAY] = '0;
			setting_vals[REG_REPEAT_ACCEL] = '0;
			setting_vals[REG_REPEAT_MIN] = '0;
		end else begin
			setting_vals[REG_DEBOUNCE] = pick_ms(25);
			setting_vals[REG_HOLD] = pick_ms(150);
			setting_vals[REG_REPEAT_DELAY] = pick_ms(80);
			setting_vals[REG_REPEAT_ACCEL] = pick_ms(30);
			setting_vals[REG_REPEAT_MIN] = pick_ms(60);
		end
	endtask

	// Next sample offset from an edge, often landing on a debounce or hold boundary.
	function automatic int unsigned next_offset(input int unsigned off, input int unsigned db,
		input int unsigned hd, input int unsigned span);
		int unsigned mark;
		case ($urandom_range(0, 7))
			0: mark = db;
			1: mark = db + 1;
			2: mark = hd;
			3: mark = hd + 1;
			default: mark = off + $urandom_range(0, span);
		endcase
		return (mark > off) ? mark : off;
	endfunction

	// One keystroke: contact chatter, a closed stretch, chatter on release, open.
	task automatic type_key();
		int unsigned      db, hd, span, off;
		logic [TimeW-1:0] edge_at;
		db = board.debounce_lim;
		hd = board.hold_lim;
		span = (db + hd + board.delay_init) / 3 + 2;
		repeat ($urandom_range(0, 2)) begin
			send_sample(1'b1, clock_ms + $urandom_range(0, db));
			send_sample(1'b0, clock_ms + $urandom_range(0, db));
		end
		edge_at = clock_ms + $urandom_range(0, span);
		send_sample(1'b1, edge_at);
		off = 0;
		repeat ($urandom_range(1, 14)) begin
			off = next_offset(off, db, hd, span);
			send_sample(1'b1, edge_at + off);
		end
		repeat ($urandom_range(0, 2)) begin
			send_sample(1'b0, clock_ms + $urandom_range(0, db));
			send_sample(1'b1, clock_ms + $urandom_range(0, db));
		end
		edge_at = clock_ms + $urandom_range(1, span);
		send_sample(1'b0, edge_at);
		off = 0;
		repeat ($urandom_range(0, 5)) begin
			off = next_offset(off, db, db, span);
			send_sample(1'b0, edge_at + off);
		end
		// Usually let the release settle so the machine gets back to idle.
		if ($urandom_range(0, 3) != 0) begin
			if (off <= db)
				off = db + 1;
			send_sample(1'b0, edge_at + off);
			send_sample(1'b0, edge_at + off + 1);
		end
	endtask

	// Random levels at random or repeated timestamps.
	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			send_sample(1'($urandom_range(0, 1)),
				($urandom_range(0, 1) != 0) ? $urandom() : clock_ms);
	endtask

	// Receiver readiness switches at random between flowing, coin-flip and sparse styles.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_style_t'($urandom_range(0, 2));
			rx_div = $urandom_range(2, 9);
			rx_left = $urandom_range(16, 120);
		end
		rx_left--;
		case (rx_mode)
			RX_FLOW:  m_tready = 1'b1;
			RX_COIN:  m_tready = 1'($urandom_range(0, 1));
			default:  m_tready = (rx_left % rx_div) == 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid && m_tready)
			board.check_report(m_tdata);
	end

	initial begin
		int unsigned target;
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		samples_sent = 0;
		clock_ms = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: a press that repeats at once, with zero characters.
		send_sample(1'b1, 32'd0);
		send_sample(1'b1, 32'd21);
		send_sample(1'b1, 32'd421);
		send_sample(1'b0, 32'd500);
		send_sample(1'b0, 32'd521);
		send_sample(1'b0, 32'd522);

		// Hold-only key, no debounce, zero repeat interval and floor.
		wait_drained();
		write_reg(REG_MAIN_CHAR, 16'hFFFF);
		write_reg(REG_ALT_CHAR, 16'h0001);
		write_reg(REG_KEY_TYPE, {14'h0, KT_HOLD_ONLY});
		write_reg(REG_DEBOUNCE, '0);
		write_reg(REG_HOLD, 16'd10);
		write_reg(REG_REPEAT_DELAY, '0);
		write_reg(REG_REPEAT_ACCEL, '0);
		write_reg(REG_REPEAT_MIN, '0);
		cfg_valid = 1'b0;

		// Short press across the timestamp wrap, then a press held past hold time.
		send_sample(1'b1, 32'hFFFF_FFFF);
		send_sample(1'b1, 32'd0);
		send_sample(1'b0, 32'd5);
		send_sample(1'b0, 32'd6);
		send_sample(1'b0, 32'd7);
		send_sample(1'b1, 32'd8);
		send_sample(1'b1, 32'd9);
		send_sample(1'b1, 32'd30);
		send_sample(1'b0, 32'd31);
		send_sample(1'b0, 32'd32);
		send_sample(1'b0, 32'd33);

		// Repeat after hold with a zero interval: a character on every sample once repeating.
		wait_drained();
		write_reg(REG_KEY_TYPE, {14'h0, KT_REPEAT_HOLD});
		cfg_valid = 1'b0;
		send_sample(1'b1, 32'd40);
		send_sample(1'b1, 32'd41);
		send_sample(1'b1, 32'd60);
		send_sample(1'b1, 32'd61);
		send_sample(1'b1, 32'd61);

		// Random keystrokes under a series of settings.
		for (int p = 0; p < 11; p++) begin
			pick_settings(p);
			load_settings();
			clock_ms = (p == 1) ? 32'hFFFF_FFC0 : $urandom();
			target = samples_sent + 105;
			while (samples_sent < target) begin
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					type_key();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (board.fails == 0 && board.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
